// ===== design/sws_pkg.sv =====
package sws_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam logic [MODE_W-1:0] MODE_PUSH    = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PEEK    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_REM_VAL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_REM_IDX = 3'd4;
    localparam logic [MODE_W-1:0] MODE_CLEAR   = 3'd5;

    typedef logic [1:0] t_shift;

    localparam t_shift SH_HOLD = 2'd0;
    localparam t_shift SH_DOWN = 2'd1;
    localparam t_shift SH_UP   = 2'd2;
    localparam t_shift SH_REM  = 2'd3;

    typedef struct packed {
        logic                     cmp_en;
        logic                     by_value;
        t_shift                   shift;
        logic signed [DATA_W-1:0] value;
        logic [IDX_W-1:0]         index;
        logic [CNT_W-1:0]         count;
    } t_cell_ctrl;

endpackage

// ===== design/sws_if.sv =====
interface sws_req_if;
    logic                              valid;
    logic                              ready;
    logic [sws_pkg::MODE_W-1:0]        mode;
    logic signed [sws_pkg::DATA_W-1:0] value;
    logic [sws_pkg::IDX_W-1:0]         index;

    modport source (output valid, mode, value, index, input ready);
    modport sink (input valid, mode, value, index, output ready);
endinterface

interface sws_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [sws_pkg::DATA_W-1:0] result_value;
    logic                              ok;
    logic [sws_pkg::CNT_W-1:0]         count;
    logic                              empty_res;

    modport source (output valid, result_value, ok, count, empty_res, input ready);
    modport sink (input valid, result_value, ok, count, empty_res, output ready);
endinterface

// ===== design/stack_with_search_removal.sv =====
// Each request runs a compare pass over the cell row, then an update pass
// in which every cell shifts or holds; the result word is registered in
// the update pass.
// A new request is taken in the update cycle of the previous one; a result
// still waiting at the output holds the update cycle until it is taken.
// Synchronous active-low reset clears the entry count and handshake state;
// cell contents are undefined until pushed.
module stack_with_search_removal (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sws_req_if.sink    i_req,
    sws_rsp_if.source  o_rsp
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CMP  = 2'd1;
    localparam logic [1:0] S_UPD  = 2'd2;

    logic [1:0]                          r_state;
    logic [1:0]                          n_state;
    logic [sws_pkg::MODE_W-1:0]          r_mode;
    logic signed [sws_pkg::DATA_W-1:0]   r_value;
    logic [sws_pkg::IDX_W-1:0]           r_index;
    logic [sws_pkg::CNT_W-1:0]           r_count;
    logic                                r_out_valid;
    logic signed [sws_pkg::DATA_W-1:0]   r_res;
    logic                                r_ok;
    logic [sws_pkg::CNT_W-1:0]           r_out_count;

    logic signed [sws_pkg::DATA_W-1:0]   n_res;
    logic                                n_ok;
    logic [sws_pkg::CNT_W-1:0]           n_count;
    sws_pkg::t_shift                     shift;
    sws_pkg::t_cell_ctrl                 ctrl;
    logic                                accept;
    logic                                upd_done;

    logic signed [sws_pkg::DATA_W-1:0]   cell_entry [sws_pkg::DEPTH];
    logic                                hit_chain [sws_pkg::DEPTH+1];

    assign upd_done    = (r_state == S_UPD) && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = (r_state == S_IDLE) || upd_done;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: n_state = S_UPD;
            S_UPD: begin
                if (upd_done) begin
                    n_state = accept ? S_CMP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_res   = '0;
        n_ok    = 1'b0;
        n_count = r_count;
        shift   = sws_pkg::SH_HOLD;
        case (r_mode)
            sws_pkg::MODE_PUSH: begin
                if (r_count < sws_pkg::CNT_W'(sws_pkg::DEPTH)) begin
                    n_count = r_count + sws_pkg::CNT_W'(1);
                    n_ok    = 1'b1;
                    shift   = sws_pkg::SH_DOWN;
                end
            end
            sws_pkg::MODE_POP: begin
                if (r_count != '0) begin
                    n_res   = cell_entry[0];
                    n_count = r_count - sws_pkg::CNT_W'(1);
                    n_ok    = 1'b1;
                    shift   = sws_pkg::SH_UP;
                end
            end
            sws_pkg::MODE_PEEK: begin
                if (r_count != '0) begin
                    n_res = cell_entry[0];
                    n_ok  = 1'b1;
                end
            end
            sws_pkg::MODE_REM_VAL, sws_pkg::MODE_REM_IDX: begin
                shift = sws_pkg::SH_REM;
                if (hit_chain[sws_pkg::DEPTH]) begin
                    n_count = r_count - sws_pkg::CNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            sws_pkg::MODE_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: n_ok = 1'b0;
        endcase
    end

    always_comb begin
        ctrl.cmp_en   = (r_state == S_CMP);
        ctrl.by_value = (r_mode == sws_pkg::MODE_REM_VAL);
        ctrl.shift    = upd_done ? shift : sws_pkg::SH_HOLD;
        ctrl.value    = r_value;
        ctrl.index    = r_index;
        ctrl.count    = r_count;
    end

    // cell 0 holds the top; a push drops everything one cell down
    assign hit_chain[0] = 1'b0;

    for (genvar k = 0; k < sws_pkg::DEPTH; k++) begin : g_cell
        logic signed [sws_pkg::DATA_W-1:0] upper;
        logic signed [sws_pkg::DATA_W-1:0] lower;

        if (k == 0) begin : g_first
            assign upper = r_value;
        end else begin : g_mid
            assign upper = cell_entry[k-1];
        end

        if (k == sws_pkg::DEPTH - 1) begin : g_last
            assign lower = '0;
        end else begin : g_inner
            assign lower = cell_entry[k+1];
        end

        sws_cell #(
            .CELL_POS (k)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_upper     (upper),
            .i_lower     (lower),
            .i_hit_above (hit_chain[k]),
            .o_entry     (cell_entry[k]),
            .o_hit_below (hit_chain[k+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (upd_done) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_req.mode;
            r_value <= i_req.value;
            r_index <= i_req.index;
        end
        if (upd_done) begin
            r_res       <= n_res;
            r_ok        <= n_ok;
            r_out_count <= n_count;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.result_value = r_res;
    assign o_rsp.ok           = r_ok;
    assign o_rsp.count        = r_out_count;
    assign o_rsp.empty_res    = (r_out_count == '0);

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= sws_pkg::CNT_W'(sws_pkg::DEPTH))
        else $error("entry count beyond depth");

    a_cmp_then_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP |=> r_state == S_UPD)
        else $error("compare pass not followed by update");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        upd_done && r_mode == sws_pkg::MODE_PUSH && n_ok
        |=> r_count == $past(r_count) + sws_pkg::CNT_W'(1))
        else $error("accepted push did not grow the stack");

    a_out_from_upd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_UPD)
        else $error("result word raised outside the update cycle");
`endif

endmodule

// ===== design/sws_cell.sv =====
module sws_cell #(
    parameter int CELL_POS = 0
) (
    input  logic                              i_clk,
    input  sws_pkg::t_cell_ctrl               i_ctrl,
    input  logic signed [sws_pkg::DATA_W-1:0] i_upper,
    input  logic signed [sws_pkg::DATA_W-1:0] i_lower,
    input  logic                              i_hit_above,
    output logic signed [sws_pkg::DATA_W-1:0] o_entry,
    output logic                              o_hit_below
);

    logic signed [sws_pkg::DATA_W-1:0] r_entry;
    logic                              r_hit;
    logic                              occupied;
    logic                              n_hit;

    assign occupied = sws_pkg::CNT_W'(CELL_POS) < i_ctrl.count;

    always_comb begin
        if (i_ctrl.by_value) begin
            n_hit = occupied && (r_entry == i_ctrl.value);
        end else begin
            n_hit = occupied && (sws_pkg::IDX_W'(CELL_POS) == i_ctrl.index);
        end
    end

    // everything below the topmost hit closes up the gap
    assign o_hit_below = i_hit_above | r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_hit <= n_hit;
        end
        case (i_ctrl.shift)
            sws_pkg::SH_DOWN: r_entry <= i_upper;
            sws_pkg::SH_UP:   r_entry <= i_lower;
            sws_pkg::SH_REM: begin
                if (o_hit_below) begin
                    r_entry <= i_lower;
                end
            end
            default: r_entry <= r_entry;
        endcase
    end

    assign o_entry = r_entry;

endmodule

// ===== tb/stack_with_search_removal_tb.sv =====
`timescale 1ns / 100ps

module stack_with_search_removal_tb;

    localparam logic [sws_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
    localparam logic [sws_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

    localparam int N_RANDOM    = 950;
    localparam int QUIET_TAIL  = 120;
    localparam int MAX_REPORTS = 10;
    localparam int SCRIPT_LEN  = 25;

    typedef struct {
        logic signed [sws_pkg::DATA_W-1:0] result_value;
        logic                              ok;
        logic [sws_pkg::CNT_W-1:0]         count;
        logic                              empty_res;
    } t_stack_result;

    typedef struct packed {
        logic [sws_pkg::MODE_W-1:0] mode;
        logic [sws_pkg::DATA_W-1:0] value;
        logic [sws_pkg::IDX_W-1:0]  index;
        logic [4:0]                 reps;
        logic                       checked;
        logic [sws_pkg::DATA_W-1:0] want_value;
        logic                       want_ok;
        logic [sws_pkg::CNT_W-1:0]  want_count;
        logic                       want_empty;
    } t_script_row;

    // Rows with checked set carry the result by hand; the rest use the mirror.
    localparam t_script_row SCRIPT [SCRIPT_LEN] = '{
        '{sws_pkg::MODE_POP, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{sws_pkg::MODE_PEEK, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{sws_pkg::MODE_REM_VAL, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{sws_pkg::MODE_REM_IDX, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{MODE_RSVD6, 32'hFFFF_FFFF, 4'd15, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{MODE_RSVD7, 32'h5555_AAAA, 4'd10, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{sws_pkg::MODE_CLEAR, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd0, 1'b1},
        '{sws_pkg::MODE_PUSH, 32'h8000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd1, 1'b0},
        '{sws_pkg::MODE_PEEK, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h8000_0000, 1'b1, 5'd1, 1'b0},
        '{sws_pkg::MODE_PUSH, 32'h7FFF_FFFF, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd2, 1'b0},
        '{sws_pkg::MODE_PUSH, 32'hFFFF_FFFF, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd3, 1'b0},
        '{sws_pkg::MODE_PUSH, 32'h0000_0005, 4'd5, 5'd13, 1'b0, 32'h0, 1'b0, 5'd0, 1'b0},
        '{sws_pkg::MODE_PUSH, 32'h0000_0001, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd16, 1'b0},
        '{sws_pkg::MODE_REM_IDX, 32'h0000_0000, 4'd15, 5'd1, 1'b1, 32'h0, 1'b1, 5'd15, 1'b0},
        '{sws_pkg::MODE_REM_IDX, 32'h0000_0000, 4'd15, 5'd1, 1'b1, 32'h0, 1'b0, 5'd15, 1'b0},
        '{sws_pkg::MODE_REM_VAL, 32'h7FFF_FFFF, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd14, 1'b0},
        '{sws_pkg::MODE_REM_VAL, 32'h0000_3039, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd14, 1'b0},
        '{sws_pkg::MODE_REM_VAL, 32'h0000_0005, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd13, 1'b0},
        '{sws_pkg::MODE_REM_IDX, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd12, 1'b0},
        '{sws_pkg::MODE_POP, 32'h0000_0000, 4'd0, 5'd1, 1'b0, 32'h0, 1'b0, 5'd0, 1'b0},
        '{sws_pkg::MODE_REM_VAL, 32'hFFFF_FFFF, 4'd0, 5'd1, 1'b0, 32'h0, 1'b0, 5'd0, 1'b0},
        '{sws_pkg::MODE_CLEAR, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd0, 1'b1},
        '{sws_pkg::MODE_POP, 32'h0000_0000, 4'd0, 5'd1, 1'b1, 32'h0, 1'b0, 5'd0, 1'b1},
        '{sws_pkg::MODE_PUSH, 32'h1234_5678, 4'd15, 5'd1, 1'b0, 32'h0, 1'b0, 5'd0, 1'b0},
        '{sws_pkg::MODE_REM_VAL, 32'h1234_5678, 4'd0, 5'd1, 1'b1, 32'h0, 1'b1, 5'd0, 1'b1}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    sws_req_if req ();
    sws_rsp_if rsp ();

    stack_with_search_removal u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mirror of the stack: slot 0 is the bottom.
    logic signed [sws_pkg::DATA_W-1:0] stack_mirror [sws_pkg::DEPTH];
    int                                mirror_count = 0;
    t_stack_result                     pending_results [$];

    int idle_level     = 1;
    int stall_left     = 0;
    int n_errors       = 0;
    int n_words        = 0;
    int n_results      = 0;
    int n_removals_hit = 0;
    int n_full_refused = 0;

    function automatic void close_slot(input int pos);
        for (int k = pos; k + 1 < mirror_count; k++)
            stack_mirror[k] = stack_mirror[k + 1];
        mirror_count--;
    endfunction

    function automatic t_stack_result apply_command(
        input logic [sws_pkg::MODE_W-1:0]        mode,
        input logic signed [sws_pkg::DATA_W-1:0] value,
        input logic [sws_pkg::IDX_W-1:0]         index);
        t_stack_result r;
        int            hit;
        r.result_value = '0;
        r.ok           = 1'b0;
        hit            = -1;
        case (mode)
            sws_pkg::MODE_PUSH: begin
                if (mirror_count < sws_pkg::DEPTH) begin
                    stack_mirror[mirror_count] = value;
                    mirror_count++;
                    r.ok = 1'b1;
                end else begin
                    n_full_refused++;
                end
            end
            sws_pkg::MODE_POP, sws_pkg::MODE_PEEK: begin
                if (mirror_count > 0) begin
                    r.result_value = stack_mirror[mirror_count - 1];
                    r.ok = 1'b1;
                    if (mode == sws_pkg::MODE_POP)
                        mirror_count--;
                end
            end
            sws_pkg::MODE_REM_VAL: begin
                // topmost match wins
                for (int k = mirror_count - 1; k >= 0 && hit < 0; k--)
                    if (stack_mirror[k] == value)
                        hit = k;
                if (hit >= 0) begin
                    close_slot(hit);
                    r.ok = 1'b1;
                    n_removals_hit++;
                end
            end
            sws_pkg::MODE_REM_IDX: begin
                if (int'(index) < mirror_count) begin
                    close_slot(mirror_count - 1 - int'(index));
                    r.ok = 1'b1;
                    n_removals_hit++;
                end
            end
            sws_pkg::MODE_CLEAR: begin
                mirror_count = 0;
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count     = sws_pkg::CNT_W'(mirror_count);
        r.empty_res = (mirror_count == 0);
        return r;
    endfunction

    task automatic send_word(input logic [sws_pkg::MODE_W-1:0]        mode,
                             input logic signed [sws_pkg::DATA_W-1:0] value,
                             input logic [sws_pkg::IDX_W-1:0]         index);
        int gap;
        gap = 0;
        if (idle_level == 1 && $urandom_range(0, 7) == 0)
            gap = $urandom_range(1, 3);
        else if (idle_level == 2 && $urandom_range(0, 2) == 0)
            gap = $urandom_range(1, 3);
        if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req.valid <= 1'b1;
        req.mode  <= mode;
        req.value <= value;
        req.index <= index;
        @(posedge i_clk);
        while (req.ready !== 1'b1) @(posedge i_clk);
        n_words++;
    endtask

    // Random commands lean toward filling or draining depending on the phase,
    // and removals mostly aim at entries that are actually held.
    task automatic choose_command(input int n,
                                  output logic [sws_pkg::MODE_W-1:0]        mode,
                                  output logic signed [sws_pkg::DATA_W-1:0] value,
                                  output logic [sws_pkg::IDX_W-1:0]         index);
        int push_pct;
        int roll;
        case ((n / 100) % 3)
            0:       push_pct = 60;
            1:       push_pct = 20;
            default: push_pct = 40;
        endcase
        value = $urandom;
        index = sws_pkg::IDX_W'($urandom_range(0, 15));
        roll  = $urandom_range(0, 99);
        if (roll < push_pct) begin
            mode = sws_pkg::MODE_PUSH;
            case ($urandom_range(0, 9))
                0:          value = 32'sh8000_0000;
                1:          value = 32'sh7FFF_FFFF;
                2, 3, 4, 5: value = $urandom_range(0, 7);
                default:    ;
            endcase
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 25)      mode = sws_pkg::MODE_POP;
            else if (roll < 40) mode = sws_pkg::MODE_PEEK;
            else if (roll < 68) mode = sws_pkg::MODE_REM_VAL;
            else if (roll < 94) mode = sws_pkg::MODE_REM_IDX;
            else if (roll < 96) mode = sws_pkg::MODE_CLEAR;
            else                mode = ($urandom_range(0, 1) != 0) ? MODE_RSVD6 : MODE_RSVD7;
            if (mode == sws_pkg::MODE_REM_VAL) begin
                if (mirror_count > 0 && $urandom_range(0, 3) != 0)
                    value = stack_mirror[$urandom_range(0, mirror_count - 1)];
                else if ($urandom_range(0, 1) != 0)
                    value = $urandom_range(0, 7);
            end
            if (mode == sws_pkg::MODE_REM_IDX && mirror_count > 0 &&
                $urandom_range(0, 9) < 7)
                index = sws_pkg::IDX_W'($urandom_range(0, mirror_count - 1));
        end
    endtask

    // Hold ready low in short bursts.
    always @(posedge i_clk) begin
        if (stall_left > 0)
            stall_left--;
        else if (idle_level == 1 && $urandom_range(0, 7) == 0)
            stall_left = $urandom_range(1, 3);
        else if (idle_level == 2 && $urandom_range(0, 2) == 0)
            stall_left = $urandom_range(1, 3);
        rsp.ready <= (stall_left == 0);
    end

    t_stack_result oldest;

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"ERROR @%0t: result word with nothing pending: ",
                              "value=%0d ok=%b count=%0d empty=%b"},
                             $realtime, rsp.result_value, rsp.ok, rsp.count,
                             rsp.empty_res);
            end else begin
                oldest = pending_results.pop_front();
                if (rsp.result_value !== oldest.result_value || rsp.ok !== oldest.ok ||
                    rsp.count !== oldest.count || rsp.empty_res !== oldest.empty_res) begin
                    n_errors++;
                    if (n_errors <= MAX_REPORTS)
                        $display({"ERROR @%0t: expected value=%0d ok=%b count=%0d empty=%b, ",
                                  "got value=%0d ok=%b count=%0d empty=%b"},
                                 $realtime, oldest.result_value, oldest.ok, oldest.count,
                                 oldest.empty_res, rsp.result_value, rsp.ok, rsp.count,
                                 rsp.empty_res);
                end
            end
        end
    end

    initial begin : stimulus
        t_stack_result                     predicted;
        logic [sws_pkg::MODE_W-1:0]        m;
        logic signed [sws_pkg::DATA_W-1:0] v;
        logic [sws_pkg::IDX_W-1:0]         ix;
        int                                waited;
        req.valid = 1'b0;
        req.mode  = sws_pkg::MODE_PUSH;
        req.value = '0;
        req.index = '0;
        rsp.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < SCRIPT_LEN; r++) begin
            for (int k = 0; k < int'(SCRIPT[r].reps); k++) begin
                send_word(SCRIPT[r].mode, SCRIPT[r].value, SCRIPT[r].index);
                predicted = apply_command(SCRIPT[r].mode, SCRIPT[r].value, SCRIPT[r].index);
                if (SCRIPT[r].checked)
                    pending_results.push_back('{SCRIPT[r].want_value, SCRIPT[r].want_ok,
                                                SCRIPT[r].want_count, SCRIPT[r].want_empty});
                else
                    pending_results.push_back(predicted);
            end
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            // no idling at all in the tail, and none in every third stretch
            idle_level = (n >= N_RANDOM - QUIET_TAIL) ? 0 : (n / 60) % 3;
            choose_command(n, m, v, ix);
            send_word(m, v, ix);
            pending_results.push_back(apply_command(m, v, ix));
        end
        req.valid <= 1'b0;

        waited = 0;
        while (pending_results.size() > 0 && waited < 2000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (8) @(posedge i_clk);
        n_errors += pending_results.size();

        $display("Run covered %0d command words and %0d result words across all six modes,",
                 n_words, n_results);
        $display("with %0d successful removals and %0d pushes refused on a full stack.",
                 n_removals_hit, n_full_refused);
        if (n_errors == 0)
            $display("PASS stack_with_search_removal");
        else
            $display("FAIL stack_with_search_removal");
        $finish;
    end

    initial begin
        #400us;
        $display("FAIL stack_with_search_removal");
        $finish;
    end

endmodule

// ===== files.f =====
design/sws_pkg.sv
design/sws_if.sv
design/sws_cell.sv
design/stack_with_search_removal.sv
tb/stack_with_search_removal_tb.sv
